>>> design/opse_pkg.sv
package opse_pkg;

   localparam int MaxDegree = 5;
   localparam int NumCoef   = MaxDegree + 1;

   localparam logic [2:0] BASIS_CHEB1    = 3'd0;
   localparam logic [2:0] BASIS_CHEB2    = 3'd1;
   localparam logic [2:0] BASIS_HERMITE  = 3'd2;
   localparam logic [2:0] BASIS_LEGENDRE = 3'd3;
   localparam logic [2:0] BASIS_LAGUERRE = 3'd4;

   localparam logic [2:0] CSR_BASIS_KIND = 3'd0;
   localparam logic [2:0] CSR_TOP_DEGREE = 3'd1;
   localparam logic [2:0] CSR_COEFF_0    = 3'd2;

   localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0] Q_ONE = 64'sh0000_0001_0000_0000;

   // reciprocals for exact 64-bit unsigned divide: /3 keeps bits 127:65 of
   // the product, /5 keeps bits 127:66
   localparam logic [31:0] RECIP3_HI = 32'hAAAA_AAAA;
   localparam logic [31:0] RECIP3_LO = 32'hAAAA_AAAB;
   localparam logic [31:0] RECIP5_HI = 32'hCCCC_CCCC;
   localparam logic [31:0] RECIP5_LO = 32'hCCCC_CCCD;

   // one in-flight pipeline slot
   typedef struct packed {
      logic                valid;
      logic                zero;
      logic                sat;
      logic signed [63:0]  x;
      logic signed [63:0]  prev;
      logic signed [63:0]  cur;
      logic signed [63:0]  sum;
   } slot_type;

   // Saturating add.
   function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                               input logic signed [63:0] b,
                                               output logic s);
      logic signed [64:0] r;
      begin
         r = {a[63], a} + {b[63], b};
         s = (r[64] != r[63]);
         sadd = s ? (r[64] ? SMIN : SMAX) : r[63:0];
      end
   endfunction

   function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                               input logic signed [63:0] b,
                                               output logic s);
      logic signed [64:0] r;
      begin
         r = {a[63], a} - {b[63], b};
         s = (r[64] != r[63]);
         ssub = s ? (r[64] ? SMIN : SMAX) : r[63:0];
      end
   endfunction

   // Saturating multiply by a small positive constant (k in 1..11).
   function automatic logic signed [63:0] smulk(input logic signed [63:0] a,
                                                input logic [3:0] k,
                                                output logic s);
      logic signed [68:0] r;
      begin
         r = {{5{a[63]}}, a} * $signed({65'd0, k});
         s = (r[68:63] != {6{r[63]}});
         smulk = s ? (r[68] ? SMIN : SMAX) : r[63:0];
      end
   endfunction

endpackage

>>> design/opse_qmul.sv
// Pipelined Q32.32 signed multiply with saturation: four 32x32 partial
// products in stage one, summed and clamped in stage two.
module opse_qmul
   import opse_pkg::*;
(
   input  logic               clock,
   input  logic               advance,
   input  logic signed [63:0] a,
   input  logic signed [63:0] b,
   output logic signed [63:0] p,
   output logic               p_sat
);

   logic [63:0] hh_ff, hl_ff, lh_ff, ll_ff;
   logic        neg_ff;
   logic [63:0] ua, ub;
   logic [127:0] full;
   logic [95:0]  mag;

   assign ua = a[63] ? (~a + 64'd1) : a;
   assign ub = b[63] ? (~b + 64'd1) : b;

   always_ff @(posedge clock) begin
      if (advance) begin
         hh_ff  <= ua[63:32] * ub[63:32];
         hl_ff  <= ua[63:32] * ub[31:0];
         lh_ff  <= ua[31:0] * ub[63:32];
         ll_ff  <= ua[31:0] * ub[31:0];
         neg_ff <= a[63] ^ b[63];
      end
   end

   assign full = {hh_ff, 64'd0} + {32'd0, hl_ff, 32'd0} + {32'd0, lh_ff, 32'd0}
               + {64'd0, ll_ff};
   assign mag = full[127:32];

   always_comb begin
      p_sat = 1'b0;
      if (neg_ff) begin
         if (mag > 96'h8000_0000_0000_0000) begin
            p_sat = 1'b1;
            p = SMIN;
         end else begin
            p = -$signed(mag[63:0]);
         end
      end else if (mag > 96'h7FFF_FFFF_FFFF_FFFF) begin
         p_sat = 1'b1;
         p = SMAX;
      end else begin
         p = $signed(mag[63:0]);
      end
   end

endmodule

>>> design/opse_step.sv
// One degree step, five register stages:
//   1. partial products of x*P(n) and coeff*P(n)
//   2. products summed and clamped
//   3. recurrence numerator and sum update
//   4. magnitude of the numerator times the reciprocal of n+1
//   5. quotient and sign restore
module opse_step
   import opse_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [2:0]         n,
   input  logic [2:0]         deg,
   input  logic [2:0]         basis_kind,
   input  logic signed [63:0] coeff,
   input  slot_type           slot_in,
   output slot_type           slot_out
);

   slot_type s1_ff, s2_ff, s3_ff, s4_ff, s5_ff;
   slot_type s3_in, s5_in;
   logic signed [63:0] xp, cp;
   logic               xp_s, cp_s;
   logic signed [63:0] xp_ff, cp_ff;
   logic               xp_s_ff, cp_s_ff;
   logic               term_on, next_on, div_on;
   logic [3:0]         kn, k2n, k2n1;
   logic [31:0]        recip_hi, recip_lo;
   logic [63:0]        mag_in, mag_ff;
   logic               neg_ff;
   logic [63:0]        dhh_ff, dhl_ff, dlh_ff, dll_ff;
   logic [127:0]       dfull;

   opse_qmul u_xp (.clock, .advance, .a(slot_in.x), .b(slot_in.cur),
                   .p(xp), .p_sat(xp_s));
   opse_qmul u_cp (.clock, .advance, .a(coeff), .b(slot_in.cur),
                   .p(cp), .p_sat(cp_s));

   assign kn   = {1'b0, n};
   assign k2n  = {n, 1'b0};
   assign k2n1 = {n, 1'b1};

   // coeff*P(n) joins the sum up to the top degree; P(n+1) only below it
   assign term_on = (deg >= n);
   assign next_on = (deg > n);
   assign div_on  = next_on && (basis_kind == BASIS_LEGENDRE || basis_kind == BASIS_LAGUERRE);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         s4_ff.valid <= 1'b0;
         s5_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_ff <= slot_in;
         s2_ff <= s1_ff;
         s3_ff <= s3_in;
         s4_ff <= s3_ff;
         s5_ff <= s5_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         xp_ff   <= xp;
         xp_s_ff <= xp_s;
         cp_ff   <= cp;
         cp_s_ff <= cp_s;
         mag_ff  <= mag_in;
         neg_ff  <= s3_ff.cur[63];
         dhh_ff  <= mag_in[63:32] * recip_hi;
         dhl_ff  <= mag_in[63:32] * recip_lo;
         dlh_ff  <= mag_in[31:0] * recip_hi;
         dll_ff  <= mag_in[31:0] * recip_lo;
      end
   end

   // Stage 3: recurrence numerator from the registered products.
   always_comb begin
      logic signed [63:0] t, u, v, nx, sm;
      logic a1, a2, a3, a4, a5;
      s3_in = s2_ff;
      t = '0; u = '0; v = '0; nx = '0;
      a1 = 1'b0; a2 = 1'b0; a3 = 1'b0; a4 = 1'b0;
      case (basis_kind)
         BASIS_CHEB1, BASIS_CHEB2: begin
            t  = smulk(xp_ff, 4'd2, a1);
            nx = ssub(t, s2_ff.prev, a2);
         end
         BASIS_HERMITE: begin
            t  = smulk(xp_ff, 4'd2, a1);
            u  = smulk(s2_ff.prev, k2n, a2);
            nx = ssub(t, u, a3);
         end
         BASIS_LEGENDRE: begin
            t  = smulk(xp_ff, k2n1, a1);
            u  = smulk(s2_ff.prev, kn, a2);
            nx = ssub(t, u, a3);
         end
         default: begin
            t  = smulk(s2_ff.cur, k2n1, a1);
            u  = ssub(t, xp_ff, a2);
            v  = smulk(s2_ff.prev, kn, a3);
            nx = ssub(u, v, a4);
         end
      endcase
      sm = sadd(s2_ff.sum, cp_ff, a5);
      if (term_on) begin
         s3_in.sum = sm;
         s3_in.sat = s3_in.sat | cp_s_ff | a5;
      end
      if (next_on) begin
         s3_in.prev = s2_ff.cur;
         s3_in.cur  = nx;
         s3_in.sat  = s3_in.sat | xp_s_ff | a1 | a2 | a3 | a4;
      end
   end

   // Stage 4: divide by n+1 on the magnitude, truncating toward zero.
   assign mag_in   = s3_ff.cur[63] ? (~s3_ff.cur + 64'd1) : s3_ff.cur;
   assign recip_hi = (n == 3'd4) ? RECIP5_HI : RECIP3_HI;
   assign recip_lo = (n == 3'd4) ? RECIP5_LO : RECIP3_LO;

   assign dfull = {dhh_ff, 64'd0} + {32'd0, dhl_ff, 32'd0} + {32'd0, dlh_ff, 32'd0}
                + {64'd0, dll_ff};

   // Stage 5: pick the quotient and restore the sign.
   always_comb begin
      logic [63:0] q;
      s5_in = s4_ff;
      case (n)
         3'd1:    q = mag_ff >> 1;
         3'd2:    q = {1'b0, dfull[127:65]};
         3'd3:    q = mag_ff >> 2;
         3'd4:    q = {2'b00, dfull[127:66]};
         default: q = mag_ff;
      endcase
      if (div_on) s5_in.cur = neg_ff ? -$signed(q) : $signed(q);
   end

   assign slot_out = s5_ff;

endmodule

>>> design/orthogonal_poly_series_eval_core.sv
// Channel | Ports                                  | Direction
// req     | req_valid, req_stall, req_sample_x     | in
// rsp     | rsp_valid, rsp_stall, rsp_series_value, rsp_saturated | out
// csr     | csr_write, csr_index, csr_data          | in
//
// One transaction per cycle while rsp_stall is low. A result passes through the entry
// register, five stages in each of the five degree steps, and the output register. The
// latency does not depend on the configured degree.
// Synchronous reset clears all valid bits and configuration registers.
// A stall on rsp freezes the whole pipeline; req_stall follows rsp_stall.
module orthogonal_poly_series_eval_core
   import opse_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_sample_x,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [63:0]        rsp_series_value,
   output logic               rsp_saturated,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_data
);

   logic [2:0] basis_kind_ff, top_degree_ff, deg;
   logic signed [63:0] coeff_ff [NumCoef];
   logic advance;
   slot_type entry_ff, entry_in;
   slot_type chain [MaxDegree + 1];
   slot_type tail_ff;

   assign advance   = !rsp_stall;
   assign req_stall = rsp_stall;
   assign deg = (top_degree_ff > 3'(MaxDegree)) ? 3'(MaxDegree) : top_degree_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         basis_kind_ff <= '0;
         top_degree_ff <= '0;
         for (int i = 0; i < NumCoef; i++) coeff_ff[i] <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_BASIS_KIND: basis_kind_ff <= csr_data[2:0];
            CSR_TOP_DEGREE: top_degree_ff <= csr_data[2:0];
            default: coeff_ff[csr_index - CSR_COEFF_0] <= csr_data;
         endcase
      end
   end

   // Entry: P0 = 1, P1 by basis, sum = coeff_0.
   always_comb begin
      entry_in.valid = req_valid;
      entry_in.zero  = req_sample_x[31] || (req_sample_x == '0) || (basis_kind_ff > BASIS_LAGUERRE);
      entry_in.sat   = 1'b0;
      entry_in.x     = {{16{req_sample_x[31]}}, req_sample_x, 16'd0};
      entry_in.prev  = Q_ONE;
      case (basis_kind_ff)
         BASIS_CHEB1, BASIS_LEGENDRE: entry_in.cur = entry_in.x;
         BASIS_LAGUERRE:              entry_in.cur = Q_ONE - entry_in.x;
         default:                     entry_in.cur = entry_in.x <<< 1;
      endcase
      entry_in.sum = coeff_ff[0];
   end

   always_ff @(posedge clock) begin
      if (reset) entry_ff.valid <= 1'b0;
      else if (advance) entry_ff <= entry_in;
   end

   // Degree 1 term is folded in by step n=1 (coeff_1 * P1), and so on.
   assign chain[0] = entry_ff;
   for (genvar g = 1; g <= MaxDegree; g++) begin : g_step
      opse_step u_step (
         .clock, .reset, .advance,
         .n(3'(g)),
         .deg(deg),
         .basis_kind(basis_kind_ff),
         .coeff(coeff_ff[g]),
         .slot_in(chain[g - 1]),
         .slot_out(chain[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) tail_ff.valid <= 1'b0;
      else if (advance) tail_ff <= chain[MaxDegree];
   end

   assign rsp_valid        = tail_ff.valid;
   assign rsp_series_value = tail_ff.zero ? 64'd0 : tail_ff.sum;
   assign rsp_saturated    = tail_ff.zero ? 1'b0 : tail_ff.sat;

`ifndef SYNTHESIS
   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && tail_ff.zero) |-> (rsp_series_value == 64'd0 && !rsp_saturated))
      else $error("zero transaction has nonzero result");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_series_value)))
      else $error("stalled result changed");
   a_back: assert property (@(posedge clock) disable iff (reset)
      rsp_stall |-> req_stall)
      else $error("input accepted while output stalled");
`endif

endmodule
